// File: hw/rtl/qclt_pkg.sv
// ----------------------------------------------------------------------------
// qclt_pkg
// Shared types, codes and character constants of the quoted command-line
// tokenizer.
// ----------------------------------------------------------------------------
package qclt_pkg;

	localparam int MaxResults = 3;

	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_QUOTE     = 8'h22;
	localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_BACKTICK  = 8'h60;

	typedef enum logic [1:0] {
		MODE_OUTSIDE = 2'd0,
		MODE_QUOTED  = 2'd1,
		MODE_ESCAPE  = 2'd2
	} scan_mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_DONE      = 2'd2,
		KIND_ERROR     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_INVALID_ESCAPE      = 2'd0,
		ERR_UNTERMINATED_ESCAPE = 2'd1,
		ERR_UNTERMINATED_QUOTE  = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [7:0] char_value;
		logic       has_char;
		logic       end_of_string;
	} cmd_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] token_char;
		err_code_t  error_code;
		logic       last_of_run;
	} tok_item_t;

	// Results of one input item, with their count.
	typedef struct packed {
		tok_item_t [MaxResults-1:0] res;
		logic [1:0]                 cnt;
	} run_t;

	// True for the characters that a backslash may escape inside quotes.
	function automatic logic is_escapable(input logic [7:0] c);
		is_escapable = (c == CHAR_QUOTE) || (c == CHAR_BACKTICK) ||
			(c == CHAR_DOLLAR) || (c == CHAR_BACKSLASH);
	endfunction

endpackage

// File: hw/rtl/quoted_command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// quoted_command_line_tokenizer_unit
// Splits a command-line string, one byte per item, into token characters,
// token ends and a final done or error result.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel carries one byte of the string per item, with has_char and
// end_of_string flags; the tok channel carries results. Both channels use
// valid and stall, and an item moves at an edge with valid high, stall low.
// Each cmd item lands in an input register, is decoded by the scanner from that
// register into zero to three results, and those results are loaded into a
// result buffer once it can take them. The buffer presents them one per cycle
// while the receiver does not stall. tok_valid for the first result of an item
// rises once the result buffer has loaded it, and the receiver can then take it.
// An item that yields at most one result leaves room for the next one, so the
// block sustains one item per cycle while the receiver does not stall. An item
// that yields two or three results holds the input register while the result
// buffer drains, since the buffer shows one result per cycle.
// When the receiver stalls, the result buffer keeps its current result and the
// input register fills, after which cmd_stall rises.
// Reset clears the scanner to outside quotes with no open token, drops any item
// held in the input register and empties the result buffer. After an invalid
// escape in mid string, items up to and including the next end-of-string item
// give no results; tokens already sent must be thrown away by the receiver.
// ----------------------------------------------------------------------------
module quoted_command_line_tokenizer_unit
	import qclt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok
);

	logic      valid_s1;
	cmd_item_t item_s1;
	logic      can_load;
	logic      take;
	run_t      run;

	// The held item moves on once the result buffer can accept its results.
	assign take      = valid_s1 && can_load;
	assign cmd_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	qclt_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (take),
		.item   (item_s1),
		.run    (run)
	);

	qclt_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.run       (run),
		.can_load  (can_load),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && tok_valid)
		else $error("quoted_command_line_tokenizer_unit: stall with room to spare");
`endif

endmodule

// File: hw/rtl/qclt_scan.sv
// ----------------------------------------------------------------------------
// qclt_scan
// Scanner state and the decode of one character into up to three results.
// ----------------------------------------------------------------------------
module qclt_scan
	import qclt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  cmd_item_t item,
	output run_t      run
);

	scan_mode_t mode_q, mode_n;
	logic       open_q, open_n;
	logic       disc_q, disc_n;

	// Next-state logic.
	always_comb begin
		mode_n = mode_q;
		open_n = open_q;
		disc_n = disc_q;
		if (disc_q) begin
			if (item.end_of_string) begin
				mode_n = MODE_OUTSIDE;
				open_n = 1'b0;
				disc_n = 1'b0;
			end
		end else begin
			if (item.has_char) begin
				case (mode_q)
					MODE_QUOTED: begin
						if (item.char_value == CHAR_QUOTE) begin
							mode_n = MODE_OUTSIDE;
						end else if (item.char_value == CHAR_BACKSLASH) begin
							mode_n = MODE_ESCAPE;
						end else begin
							open_n = 1'b1;
						end
					end
					MODE_ESCAPE: begin
						if (is_escapable(item.char_value)) begin
							open_n = 1'b1;
							mode_n = MODE_QUOTED;
						end else begin
							disc_n = 1'b1;
						end
					end
					default: begin
						if (item.char_value == CHAR_SPACE) begin
							open_n = 1'b0;
						end else if (item.char_value == CHAR_QUOTE) begin
							mode_n = MODE_QUOTED;
						end else begin
							open_n = 1'b1;
						end
					end
				endcase
			end
			if (item.end_of_string) begin
				mode_n = MODE_OUTSIDE;
				open_n = 1'b0;
				disc_n = 1'b0;
			end
		end
	end

	// Result logic.
	always_comb begin
		run = '0;
		if (!disc_q) begin
			if (item.has_char) begin
				case (mode_q)
					MODE_QUOTED: begin
						if (item.char_value != CHAR_QUOTE &&
							item.char_value != CHAR_BACKSLASH) begin
							run.res[run.cnt].kind       = KIND_CHAR;
							run.res[run.cnt].token_char = item.char_value;
							run.cnt = run.cnt + 2'd1;
						end
					end
					MODE_ESCAPE: begin
						if (is_escapable(item.char_value)) begin
							run.res[run.cnt].kind       = KIND_CHAR;
							run.res[run.cnt].token_char = item.char_value;
						end else begin
							run.res[run.cnt].kind       = KIND_ERROR;
							run.res[run.cnt].error_code = ERR_INVALID_ESCAPE;
						end
						run.cnt = run.cnt + 2'd1;
					end
					default: begin
						if (item.char_value == CHAR_SPACE) begin
							if (open_q) begin
								run.res[run.cnt].kind = KIND_TOKEN_END;
								run.cnt = run.cnt + 2'd1;
							end
						end else if (item.char_value != CHAR_QUOTE) begin
							run.res[run.cnt].kind       = KIND_CHAR;
							run.res[run.cnt].token_char = item.char_value;
							run.cnt = run.cnt + 2'd1;
						end
					end
				endcase
			end
			// A failed escape already closed the string with its error.
			if (item.end_of_string && !(disc_n && !disc_q) &&
				!(item.has_char && mode_q == MODE_ESCAPE &&
				!is_escapable(item.char_value))) begin
				// The string ends inside quotes when its last character opens a
				// quoted run, stays inside one, or completes an escape.
				if ((item.has_char && item.char_value == CHAR_QUOTE &&
					mode_q != MODE_QUOTED && mode_q != MODE_ESCAPE) ||
					(mode_q == MODE_QUOTED &&
					item.has_char && item.char_value != CHAR_QUOTE &&
					item.char_value != CHAR_BACKSLASH) ||
					(!item.has_char && mode_q == MODE_QUOTED) ||
					(item.has_char && mode_q == MODE_ESCAPE)) begin
					run.res[run.cnt].kind       = KIND_ERROR;
					run.res[run.cnt].error_code = ERR_UNTERMINATED_QUOTE;
					run.cnt = run.cnt + 2'd1;
				end else if ((item.has_char && mode_q == MODE_QUOTED &&
					item.char_value == CHAR_BACKSLASH) ||
					(!item.has_char && mode_q == MODE_ESCAPE)) begin
					run.res[run.cnt].kind       = KIND_ERROR;
					run.res[run.cnt].error_code = ERR_UNTERMINATED_ESCAPE;
					run.cnt = run.cnt + 2'd1;
				end else begin
					if (open_q && !(item.has_char && item.char_value == CHAR_SPACE &&
						mode_q != MODE_QUOTED && mode_q != MODE_ESCAPE) ||
						(item.has_char && item.char_value != CHAR_SPACE &&
						item.char_value != CHAR_QUOTE &&
						mode_q != MODE_QUOTED && mode_q != MODE_ESCAPE) ||
						(item.has_char && mode_q == MODE_QUOTED &&
						item.char_value == CHAR_QUOTE && open_q)) begin
						run.res[run.cnt].kind = KIND_TOKEN_END;
						run.cnt = run.cnt + 2'd1;
					end
					run.res[run.cnt].kind = KIND_DONE;
					run.cnt = run.cnt + 2'd1;
				end
			end
			if (run.cnt != 2'd0) begin
				run.res[run.cnt - 2'd1].last_of_run = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OUTSIDE;
			open_q <= 1'b0;
			disc_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_n;
			open_q <= open_n;
			disc_q <= disc_n;
		end
	end

`ifndef SYNTHESIS
	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> run.cnt == 2'd0)
		else $error("qclt_scan: results produced while discarding");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_string |=> mode_q == MODE_OUTSIDE && !open_q && !disc_q)
		else $error("qclt_scan: state not cleared after end of string");
`endif

endmodule

// File: hw/rtl/qclt_result_buf.sv
// ----------------------------------------------------------------------------
// qclt_result_buf
// Holds the results of one input item and hands them out one per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module qclt_result_buf
	import qclt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  run_t      run,
	output logic      can_load,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok
);

	tok_item_t [MaxResults-1:0] res_q;
	logic [1:0]                 rem_q;
	logic [1:0]                 idx_q;
	logic                       pop;

	assign tok_valid = (rem_q != 2'd0);
	assign tok       = res_q[idx_q];
	assign pop       = tok_valid && !tok_stall;
	assign can_load  = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load && run.cnt != 2'd0) begin
			rem_q <= run.cnt;
			idx_q <= 2'd0;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && run.cnt != 2'd0) begin
			res_q <= run.res;
		end
	end

`ifndef SYNTHESIS
	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == 2'd1 |-> tok.last_of_run)
		else $error("qclt_result_buf: final result lacks last mark");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == 2'd2 || rem_q == 2'd3 |-> !tok.last_of_run)
		else $error("qclt_result_buf: last mark before final result");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the quoted command-line tokenizer.
// ----------------------------------------------------------------------------
// Command strings go in one byte per item on the cmd channel. Every accepted
// item runs through a local scanner that mirrors the tokenizer's quote,
// escape and error handling. The results it owes are queued, and each result
// on the tok channel is checked field by field against the oldest of them.
// A short scripted part comes first, then randomly built strings. Most random
// strings are well formed, some are broken, and a few noise items are mixed
// in. Both sides idle at random. A quiet window has no idling at all, and a
// long receiver hold-off makes the block fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qclt_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 12;
	localparam int IDLE_PCT        = 21;
	localparam int RANDOM_ITEMS    = 360;
	localparam int HOLDOFF_CYCLES  = 120;
	localparam int DRAIN_CYCLES    = 10;
	localparam int TIMEOUT_CYCLES  = 60000;
	// Random strings, counted from zero, that bound the quiet window and the burst
	// in which the receiver holds off.
	localparam int QUIET_FIRST     = 3;
	localparam int QUIET_LAST      = 8;
	localparam int BURST_FIRST     = 10;
	localparam int BURST_LAST      = 16;

	localparam logic [7:0] LETTER_A = 8'h61;

	// The error field reads as its first code whenever a result is not an error.
	localparam err_code_t ERR_IDLE = ERR_INVALID_ESCAPE;

	// One row of the scripted part: the item and, where it is obvious, the
	// results typed in by hand. Rows without typed results use the scanner.
	typedef struct packed {
		cmd_item_t item;
		logic      fixed;
		run_t      want;
	} script_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      tok_valid;
	logic      tok_stall;
	tok_item_t tok;

	script_row_t script_rows[$];
	cmd_item_t   string_items[$];
	tok_item_t   token_backlog[$];
	tok_item_t   scan_out[$];

	// Scanner state, kept apart from the block's own.
	scan_mode_t pred_mode;
	logic       pred_in_token;
	logic       pred_skipping;

	int   failures        = 0;
	int   items_sent      = 0;
	int   strings_sent    = 0;
	int   results_checked = 0;
	int   done_seen       = 0;
	int   errors_seen     = 0;
	int   stall_run       = 0;
	int   longest_stall   = 0;
	int   send_idle_pct   = IDLE_PCT;
	int   recv_idle_pct   = IDLE_PCT;
	int   holdoff_left    = 0;
	logic pressure_start  = 1'b0;
	logic holdoff_taken   = 1'b0;

	quoted_command_line_tokenizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Scanner
	// ------------------------------------------------------------------------

	function automatic void clear_scan();
		pred_mode     = MODE_OUTSIDE;
		pred_in_token = 1'b0;
		pred_skipping = 1'b0;
	endfunction

	function automatic tok_item_t tok_res(kind_t k, logic [7:0] c, err_code_t e);
		tok_item_t r;
		r.kind        = k;
		r.token_char  = c;
		r.error_code  = e;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic logic escapable(logic [7:0] c);
		return c == CHAR_QUOTE || c == CHAR_BACKTICK || c == CHAR_DOLLAR ||
			c == CHAR_BACKSLASH;
	endfunction

	// Works out the results of one item into scan_out and moves the scanner on.
	function automatic void scan_byte(cmd_item_t it);
		logic      failed;
		tok_item_t tail;
		failed = 1'b0;
		scan_out.delete();
		// After an error everything up to the end mark vanishes without a trace.
		if (pred_skipping) begin
			if (it.end_of_string)
				clear_scan();
			return;
		end
		if (it.has_char) begin
			case (pred_mode)
				MODE_QUOTED: begin
					if (it.char_value == CHAR_QUOTE) begin
						pred_mode = MODE_OUTSIDE;
					end else if (it.char_value == CHAR_BACKSLASH) begin
						pred_mode = MODE_ESCAPE;
					end else begin
						scan_out.push_back(tok_res(KIND_CHAR, it.char_value, ERR_IDLE));
						pred_in_token = 1'b1;
					end
				end
				MODE_ESCAPE: begin
					if (escapable(it.char_value)) begin
						scan_out.push_back(tok_res(KIND_CHAR, it.char_value, ERR_IDLE));
						pred_in_token = 1'b1;
						pred_mode     = MODE_QUOTED;
					end else begin
						scan_out.push_back(tok_res(KIND_ERROR, 8'h00, ERR_INVALID_ESCAPE));
						failed = 1'b1;
					end
				end
				default: begin
					// Outside quotes; the unused mode code behaves the same way.
					if (it.char_value == CHAR_SPACE) begin
						if (pred_in_token)
							scan_out.push_back(tok_res(KIND_TOKEN_END, 8'h00, ERR_IDLE));
						pred_in_token = 1'b0;
					end else if (it.char_value == CHAR_QUOTE) begin
						pred_mode = MODE_QUOTED;
					end else begin
						scan_out.push_back(tok_res(KIND_CHAR, it.char_value, ERR_IDLE));
						pred_in_token = 1'b1;
					end
				end
			endcase
		end
		if (failed) begin
			if (it.end_of_string)
				clear_scan();
			else
				pred_skipping = 1'b1;
		end else if (it.end_of_string) begin
			case (pred_mode)
				MODE_QUOTED:
					scan_out.push_back(tok_res(KIND_ERROR, 8'h00, ERR_UNTERMINATED_QUOTE));
				MODE_ESCAPE:
					scan_out.push_back(tok_res(KIND_ERROR, 8'h00, ERR_UNTERMINATED_ESCAPE));
				default: begin
					if (pred_in_token)
						scan_out.push_back(tok_res(KIND_TOKEN_END, 8'h00, ERR_IDLE));
					scan_out.push_back(tok_res(KIND_DONE, 8'h00, ERR_IDLE));
				end
			endcase
			clear_scan();
		end
		if (scan_out.size() != 0) begin
			tail             = scan_out.pop_back();
			tail.last_of_run = 1'b1;
			scan_out.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Scripted part
	// ------------------------------------------------------------------------

	function automatic void add_row(logic [7:0] c, logic has, logic eos, logic fixed, int n,
		tok_item_t r0, tok_item_t r1);
		script_row_t row;
		row.item.char_value    = c;
		row.item.has_char      = has;
		row.item.end_of_string = eos;
		row.fixed              = fixed;
		row.want.res           = '0;
		row.want.res[0]        = r0;
		row.want.res[1]        = r1;
		row.want.cnt           = 2'(n);
		if (n > 0)
			row.want.res[n-1].last_of_run = 1'b1;
		script_rows.push_back(row);
	endfunction

	function automatic void load_script();
		// Empty string right after reset: only the done result.
		add_row(8'h00, 1'b0, 1'b1, 1'b1, 1, tok_res(KIND_DONE, 8'h00, ERR_IDLE), '0);
		// An item with neither a character nor an end mark does nothing.
		add_row(8'hFF, 1'b0, 1'b0, 1'b1, 0, '0, '0);
		// The lowest and highest bytes are ordinary token characters.
		add_row(8'h00, 1'b1, 1'b0, 1'b1, 1, tok_res(KIND_CHAR, 8'h00, ERR_IDLE), '0);
		add_row(8'hFF, 1'b1, 1'b0, 1'b1, 1, tok_res(KIND_CHAR, 8'hFF, ERR_IDLE), '0);
		add_row(CHAR_SPACE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		// A quoted empty token appends nothing, so the string just ends.
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_QUOTE, 1'b1, 1'b1, 1'b0, 0, '0, '0);
		// All four escapes and a quoted space, then a last character with the end mark.
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKTICK, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_DOLLAR, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_SPACE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(8'h7A, 1'b1, 1'b1, 1'b0, 0, '0, '0);
		// Invalid escape in mid string; the rest of the string is dropped.
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(8'h71, 1'b1, 1'b0, 1'b1, 1, tok_res(KIND_ERROR, 8'h00, ERR_INVALID_ESCAPE), '0);
		add_row(8'h62, 1'b1, 1'b1, 1'b0, 0, '0, '0);
		// The string ends inside quotes.
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(8'h63, 1'b1, 1'b1, 1'b1, 2, tok_res(KIND_CHAR, 8'h63, ERR_IDLE),
			tok_res(KIND_ERROR, 8'h00, ERR_UNTERMINATED_QUOTE));
		// The string ends right after a backslash.
		add_row(CHAR_QUOTE, 1'b1, 1'b0, 1'b0, 0, '0, '0);
		add_row(CHAR_BACKSLASH, 1'b1, 1'b1, 1'b1, 1,
			tok_res(KIND_ERROR, 8'h00, ERR_UNTERMINATED_ESCAPE), '0);
	endfunction

	// ------------------------------------------------------------------------
	// Random strings
	// ------------------------------------------------------------------------

	// Appends one character item, now and then after a noise item that carries
	// neither a character nor an end mark.
	function automatic void push_char(logic [7:0] c);
		cmd_item_t it;
		if ($urandom_range(99) < 5) begin
			it.char_value    = 8'($urandom_range(255));
			it.has_char      = 1'b0;
			it.end_of_string = 1'b0;
			string_items.push_back(it);
		end
		it.char_value    = c;
		it.has_char      = 1'b1;
		it.end_of_string = 1'b0;
		string_items.push_back(it);
	endfunction

	// Any byte that stays in the token outside quotes.
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		if ($urandom_range(99) < 60)
			return LETTER_A + 8'($urandom_range(25));
		do
			c = 8'($urandom_range(255));
		while (c == CHAR_SPACE || c == CHAR_QUOTE);
		return c;
	endfunction

	// Any byte that stays in the token inside quotes, spaces included.
	function automatic logic [7:0] quoted_byte();
		logic [7:0] c;
		if ($urandom_range(99) < 15)
			return CHAR_SPACE;
		do
			c = 8'($urandom_range(255));
		while (c == CHAR_QUOTE || c == CHAR_BACKSLASH);
		return c;
	endfunction

	function automatic logic [7:0] escape_target();
		case ($urandom_range(3))
			0:       return CHAR_QUOTE;
			1:       return CHAR_BACKTICK;
			2:       return CHAR_DOLLAR;
			default: return CHAR_BACKSLASH;
		endcase
	endfunction

	function automatic logic [7:0] bad_escape_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (escapable(c));
		return c;
	endfunction

	// Builds one string: up to four tokens made of plain characters and quoted
	// runs with escapes, spaces between them, and now and then a broken tail.
	function automatic void build_random_string();
		int        n_tok;
		int        n_part;
		int        n_in;
		int        shape;
		cmd_item_t tail;
		string_items.delete();
		n_tok = $urandom_range(4);
		if ($urandom_range(99) < 20)
			push_char(CHAR_SPACE);
		for (int t = 0; t < n_tok; t++) begin
			n_part = $urandom_range(1, 4);
			for (int p = 0; p < n_part; p++) begin
				shape = $urandom_range(99);
				if (shape < 55) begin
					push_char(plain_byte());
				end else if (shape < 92) begin
					push_char(CHAR_QUOTE);
					n_in = $urandom_range(4);
					for (int k = 0; k < n_in; k++) begin
						if ($urandom_range(99) < 25) begin
							push_char(CHAR_BACKSLASH);
							push_char(escape_target());
						end else begin
							push_char(quoted_byte());
						end
					end
					push_char(CHAR_QUOTE);
				end else begin
					// Outside quotes a backslash is an ordinary character.
					push_char(CHAR_BACKSLASH);
				end
			end
			if (t < n_tok - 1 || $urandom_range(99) < 25)
				repeat ($urandom_range(1, 2)) push_char(CHAR_SPACE);
		end
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(2))
				0: begin
					push_char(CHAR_QUOTE);
					push_char(CHAR_BACKSLASH);
					push_char(bad_escape_byte());
					repeat ($urandom_range(3)) push_char(plain_byte());
				end
				1: begin
					push_char(CHAR_QUOTE);
					repeat ($urandom_range(2)) push_char(quoted_byte());
				end
				default: begin
					push_char(CHAR_QUOTE);
					push_char(CHAR_BACKSLASH);
				end
			endcase
		end
		// The end mark rides on the last character or comes as an item of its own.
		if (string_items.size() != 0 && $urandom_range(1) == 1) begin
			tail               = string_items.pop_back();
			tail.end_of_string = 1'b1;
			string_items.push_back(tail);
		end else begin
			tail.char_value    = 8'($urandom_range(255));
			tail.has_char      = 1'b0;
			tail.end_of_string = 1'b1;
			string_items.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Offers one item, starting just after a falling edge and returning just
	// after the falling edge that follows its acceptance. The item and valid
	// stay put while the block stalls.
	task automatic send_item(cmd_item_t it, logic fixed, run_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= it;
		do
			@(posedge clk);
		while (cmd_stall);
		scan_byte(it);
		if (fixed) begin
			for (int i = 0; i < int'(want.cnt); i++)
				token_backlog.push_back(want.res[i]);
		end else begin
			while (scan_out.size() != 0)
				token_backlog.push_back(scan_out.pop_front());
		end
		if (it.has_char || it.end_of_string)
			items_sent++;
		@(negedge clk);
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		clear_scan();
		load_script();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script_rows[r])
			send_item(script_rows[r].item, script_rows[r].fixed, script_rows[r].want);

		while (items_sent < script_rows.size() + RANDOM_ITEMS) begin
			// A window of strings with no idling on either side, and later a burst
			// in which the sender never idles while the receiver holds off.
			if (strings_sent >= QUIET_FIRST && strings_sent < QUIET_LAST) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (strings_sent >= BURST_FIRST && strings_sent < BURST_LAST) begin
				send_idle_pct  = 0;
				recv_idle_pct  = IDLE_PCT;
				pressure_start = 1'b1;
			end else begin
				send_idle_pct = IDLE_PCT;
				recv_idle_pct = IDLE_PCT;
			end
			build_random_string();
			foreach (string_items[r])
				send_item(string_items[r], 1'b0, '0);
			strings_sent++;
		end
		cmd_valid <= 1'b0;

		// Wait for every owed result, then a little longer for strays.
		while (token_backlog.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (token_backlog.size() != 0) begin
			failures++;
			$display("%0t: %0d results never arrived", $time, token_backlog.size());
		end

		$display("Drove %0d string items (%0d random strings after the scripted ones)",
			items_sent, strings_sent);
		$display("and checked %0d results: %0d strings done, %0d errors.",
			results_checked, done_seen, errors_seen);
		$display("The longest input stall while the receiver held off lasted %0d cycles.",
			longest_stall);
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver
	// ------------------------------------------------------------------------

	// Stalls at random. Once the burst starts, it holds off for a long count
	// of cycles so that the block fills up and stalls its input.
	initial begin : receiver
		tok_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_start && !holdoff_taken) begin
				holdoff_taken = 1'b1;
				holdoff_left  = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				tok_stall <= 1'b1;
				holdoff_left--;
			end else begin
				tok_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker
	// ------------------------------------------------------------------------

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin : watch_results
		tok_item_t want;
		if (cmd_valid && cmd_stall) begin
			stall_run++;
			if (stall_run > longest_stall)
				longest_stall = stall_run;
		end else begin
			stall_run = 0;
		end
		if (arst_n && tok_valid && !tok_stall) begin
			if (token_backlog.size() == 0) begin
				failures++;
				$display("%0t: unexpected result, expected none, got kind %0d char %h",
					$time, tok.kind, tok.token_char);
				$display("%0t: unexpected result has code %0d last %b",
					$time, tok.error_code, tok.last_of_run);
			end else begin
				want = token_backlog.pop_front();
				check_field("kind", want.kind, tok.kind);
				check_field("token_char", want.token_char, tok.token_char);
				check_field("error_code", want.error_code, tok.error_code);
				check_field("last_of_run", want.last_of_run, tok.last_of_run);
				results_checked++;
			end
			if (tok.kind == KIND_DONE)
				done_seen++;
			if (tok.kind == KIND_ERROR)
				errors_seen++;
		end
	end

	// Hard stop in case the handshake hangs.
	initial begin : watchdog
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("%0t: run did not finish in time", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
